// ----- rtl/i2cmat_pkg.sv -----
`timescale 1ns / 1ps

package i2cmat_pkg;

    // Transmit buffer geometry (depth must be a power of two)
    localparam int TX_DEPTH = 256;
    localparam int TX_IDX_W = $clog2(TX_DEPTH);

    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_W     = 16;
    localparam int ADDR_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 2;
    localparam int EVENT_W     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_EN    = 2'd2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NACK  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_WADDR = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DATA  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_RADDR = 3'd3;
    localparam logic [EVENT_W-1:0] EV_NEXT  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_STOP  = 3'd5;
    localparam logic [EVENT_W-1:0] EV_NONE  = 3'd6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_SEND = 2'd2
    } phase_t;

    // One result, before the buffer byte is merged in
    typedef struct packed {
        logic [EVENT_W-1:0] event_kind;
        logic [ADDR_W-1:0]  target_address;
        logic [BYTE_W-1:0]  data_byte;
        logic               ack;
        logic [COUNT_W-1:0] byte_length;
        logic               use_buffer;
    } result_t;

    // Decoder verdict for one transfer
    typedef struct packed {
        phase_t             phase_next;
        logic [COUNT_W-1:0] count_next;
        logic               tx_advance;
        logic               tx_rewind;
        result_t            result;
    } step_t;

endpackage

// ----- rtl/i2cmat_if.sv -----
`timescale 1ns / 1ps

interface i2cmat_req_if;
    import i2cmat_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] bus_byte;
    logic [BYTE_W-1:0] load_index;
    logic [BYTE_W-1:0] load_value;

    modport source (output valid, command, bus_byte, load_index, load_value, input ready);
    modport sink   (input valid, command, bus_byte, load_index, load_value, output ready);
endinterface

interface i2cmat_rsp_if;
    import i2cmat_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_kind;
    logic [ADDR_W-1:0]  target_address;
    logic [BYTE_W-1:0]  data_byte;
    logic               ack;
    logic [COUNT_W-1:0] byte_length;

    modport source (output valid, event_kind, target_address, data_byte, ack, byte_length,
                    input ready);
    modport sink   (input valid, event_kind, target_address, data_byte, ack, byte_length,
                    output ready);
endinterface

// ----- rtl/i2cmat_decode.sv -----
`timescale 1ns / 1ps

module i2cmat_decode (
    input  i2cmat_pkg::phase_t                    phase,
    input  logic [i2cmat_pkg::CMD_W-1:0]          command,
    input  logic [i2cmat_pkg::BYTE_W-1:0]         bus_byte,
    input  logic [i2cmat_pkg::COUNT_W-1:0]        byte_count,
    input  logic                                  tx_enable,
    input  logic [2*i2cmat_pkg::CFG_W-1:0]        address_map,
    output i2cmat_pkg::step_t                     step
);
    import i2cmat_pkg::*;

    logic [ADDR_W-1:0]  addr;
    logic               addr_hit;
    logic               read_bit;
    logic [COUNT_W-1:0] count_inc;
    phase_t             phase_next;
    logic [COUNT_W-1:0] count_next;
    logic               tx_take;
    logic               tx_rewind;
    result_t            result;

    assign addr      = bus_byte[BYTE_W-1:1];
    assign read_bit  = bus_byte[0];
    assign addr_hit  = address_map[addr];
    assign count_inc = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;

    // Next state
    always_comb
    begin
        phase_next = phase;
        count_next = byte_count;
        tx_take    = 1'b0;
        tx_rewind  = 1'b0;
        case (command)
            CMD_BYTE:
            begin
                case (phase)
                    PH_IDLE:
                    begin
                        count_next = '0;
                        if (addr_hit)
                        begin
                            phase_next = read_bit ? PH_SEND : PH_RECV;
                            tx_take    = read_bit;
                        end
                    end
                    PH_RECV: count_next = count_inc;
                    PH_SEND:
                    begin
                        count_next = count_inc;
                        tx_take    = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_STOP:
            begin
                if (phase != PH_IDLE)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    tx_rewind  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result fields
    always_comb
    begin
        result            = '0;
        result.event_kind = EV_NONE;
        case (command)
            CMD_BYTE:
            begin
                case (phase)
                    PH_IDLE:
                    begin
                        result.target_address = addr;
                        if (!addr_hit)
                        begin
                            result.event_kind = EV_NACK;
                        end
                        else if (read_bit)
                        begin
                            result.event_kind = EV_RADDR;
                            result.ack        = 1'b1;
                            result.use_buffer = tx_enable;
                        end
                        else
                        begin
                            result.event_kind = EV_WADDR;
                            result.ack        = 1'b1;
                        end
                    end
                    PH_RECV:
                    begin
                        result.event_kind = EV_DATA;
                        result.data_byte  = bus_byte;
                        result.ack        = 1'b1;
                    end
                    PH_SEND:
                    begin
                        result.event_kind = EV_NEXT;
                        result.use_buffer = tx_enable;
                    end
                    default: ;
                endcase
            end
            CMD_STOP:
            begin
                if (phase != PH_IDLE)
                begin
                    result.event_kind  = EV_STOP;
                    result.byte_length = byte_count;
                end
            end
            default: ;
        endcase
    end

    assign step.phase_next = phase_next;
    assign step.count_next = count_next;
    assign step.tx_advance = tx_take & tx_enable;
    assign step.tx_rewind  = tx_rewind;
    assign step.result     = result;

endmodule

// ----- rtl/i2c_multi_address_target.sv -----
`timescale 1ns / 1ps

// Transaction-level I2C target answering on any seven-bit address enabled in a
// 128-bit map. Each request transfer (bus byte, stop, or buffer load) yields
// exactly one response transfer, in order. Throughput is one request per clock
// while responses are taken; a response passes the stage 1 register (decode
// plus transmit-buffer read on the accept edge), then the output register. The
// transmit buffer is a 256 x 8 single-write memory read at the current buffer
// index on every accept edge; it has no reset and needs no clearing pass, so
// the block is ready right after reset. Entries must be loaded before a read
// transaction hands them out. Configuration writes are only allowed while no
// response is pending; writing tx_enable also rewinds the buffer index.

module i2c_multi_address_target (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [i2cmat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cmat_pkg::CFG_W-1:0]        cfg_data,
    i2cmat_req_if.sink                          req,
    i2cmat_rsp_if.source                        rsp
);
    import i2cmat_pkg::*;

    // Configuration
    logic [CFG_W-1:0]    map_low_reg;
    logic [CFG_W-1:0]    map_high_reg;
    logic                tx_enable_reg;

    // Transaction state
    phase_t              phase_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [TX_IDX_W-1:0] tx_index_reg;
    logic [TX_IDX_W-1:0] tx_index_next;

    // Stage 1: decoded result plus buffer read
    logic                s1_valid_reg;
    logic                s1_valid_next;
    result_t             s1_result_reg;
    logic [BYTE_W-1:0]   rd_data_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [EVENT_W-1:0]  out_event_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [BYTE_W-1:0]   out_data_reg;
    logic                out_ack_reg;
    logic [COUNT_W-1:0]  out_length_reg;

    logic [BYTE_W-1:0]   tx_mem [TX_DEPTH];

    step_t               step;
    logic                accept;
    logic                s1_move;
    logic                load_write;
    logic [TX_IDX_W-1:0] load_addr;

    i2cmat_decode u_decode (
        .phase       (phase_reg),
        .command     (req.command),
        .bus_byte    (req.bus_byte),
        .byte_count  (count_reg),
        .tx_enable   (tx_enable_reg),
        .address_map ({map_high_reg, map_low_reg}),
        .step        (step)
    );

    // Stage 1 drains into the output register when that is empty or being taken,
    // so a new request can land while a finished response waits.
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;
    assign accept    = req.valid && req.ready;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && !rsp.ready);

    assign load_write = accept && (req.command == CMD_LOAD);
    // Index taken modulo the (power of two) depth
    assign load_addr  = TX_IDX_W'(req.load_index);

    // Buffer index: config write of tx_enable or a stop rewinds; wraps at depth
    always_comb
    begin
        tx_index_next = tx_index_reg;
        if (cfg_write_en && (cfg_index == CFG_TX_EN))
        begin
            tx_index_next = '0;
        end
        else if (accept)
        begin
            if (step.tx_rewind)
            begin
                tx_index_next = '0;
            end
            else if (step.tx_advance)
            begin
                tx_index_next = tx_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_low_reg   <= '0;
            map_high_reg  <= '0;
            tx_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MAP_LOW:  map_low_reg   <= cfg_data;
                CFG_MAP_HIGH: map_high_reg  <= cfg_data;
                CFG_TX_EN:    tx_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            tx_index_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= step.phase_next;
                count_reg <= step.count_next;
            end
            tx_index_reg  <= tx_index_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_result_reg <= step.result;
        end
        if (s1_move)
        begin
            out_event_reg  <= s1_result_reg.event_kind;
            out_addr_reg   <= s1_result_reg.target_address;
            out_data_reg   <= s1_result_reg.use_buffer ? rd_data_reg
                                                       : s1_result_reg.data_byte;
            out_ack_reg    <= s1_result_reg.ack;
            out_length_reg <= s1_result_reg.byte_length;
        end
    end

    // Transmit buffer: one write port for loads, one registered read at the index
    always_ff @(posedge clk)
    begin
        if (load_write)
        begin
            tx_mem[load_addr] <= req.load_value;
        end
        if (accept)
        begin
            rd_data_reg <= tx_mem[tx_index_reg];
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.event_kind     = out_event_reg;
    assign rsp.target_address = out_addr_reg;
    assign rsp.data_byte      = out_data_reg;
    assign rsp.ack            = out_ack_reg;
    assign rsp.byte_length    = out_length_reg;

    // A stop that ends a transaction always leaves the target idle
    a_stop_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.command == CMD_STOP)) |=> (phase_reg == PH_IDLE))
        else $error("stop transfer did not return to idle");

    // With the buffer disabled the index never leaves entry zero
    a_index_parked: assert property (@(posedge clk) disable iff (!rst_n)
        !tx_enable_reg |-> (tx_index_reg == '0))
        else $error("buffer index moved while buffer disabled");

    // Ack only on address matches and received data
    a_ack_events: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ack) |-> ((rsp.event_kind == EV_WADDR) ||
                                    (rsp.event_kind == EV_DATA) ||
                                    (rsp.event_kind == EV_RADDR)))
        else $error("ack on non-acknowledged event");

    // Byte count is reported on stop events only
    a_length_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.event_kind != EV_STOP)) |-> (rsp.byte_length == '0))
        else $error("byte length outside stop event");

endmodule
